>>> hdl/signed_int_to_decimal_ascii_defines.svh
// Assertion macros for the signed integer to decimal ASCII converter.
// Included by the RTL files that assert; depends on nothing else.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define SIDA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define SIDA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sida_pkg.sv
// Types and constants for the signed integer to decimal ASCII converter.
// No dependencies.
`default_nettype none

package sida_pkg;

    // Digit storage: a 32-bit magnitude has at most ten decimal digits
    localparam int DIGITS_MAX = 10;
    localparam int DIG_CNT_W  = $clog2(DIGITS_MAX + 1);
    localparam int DIG_IDX_W  = $clog2(DIGITS_MAX);

    // Divide by ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for all 32-bit x
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    // ASCII characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Sign mode register codes
    typedef enum logic [1:0] {
        SIGN_NONE  = 2'd0,
        SIGN_PLUS  = 2'd1,
        SIGN_SPACE = 2'd2
    } sign_mode_t;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_DIGIT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

>>> hdl/signed_int_to_decimal_ascii.sv
// Converts one 32-bit two's complement integer per input beat into its decimal
// text, sent as one ASCII character per output beat, most significant digit first,
// with no leading zeros; a negative value is preceded by '-', and a value of zero or
// more by '+', ' ' or nothing as sign_mode (cfg_wdata) selects, code 3 meaning none.
// m_last marks the final character. One shared 32x32 reciprocal multiplier
// peels the digits one at a time (multiply, then quotient and remainder); the
// characters then leave one per cycle while m_ready is high. s_ready is high only
// while the sequencer is idle; the last character may still wait in the output
// register while the next number is accepted.
// Depends on sida_pkg and signed_int_to_decimal_ascii_defines.svh.
`default_nettype none

`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_wdata,
    // input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_value,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_out_char,
    output logic                    m_last
);

    import sida_pkg::*;

    // Control state
    state_t                 state_reg, state_next;
    logic [1:0]             sign_mode_reg;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                   sign_pend_reg, sign_pend_next;
    logic                   m_valid_reg, m_valid_next;

    // Datapath
    logic [31:0]            mag_reg, mag_next;
    logic [63:0]            prod_reg, prod_next;
    logic [7:0]             sign_char_reg, sign_char_next;
    logic [7:0]             m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;
    logic [3:0]             digits_reg [DIGITS_MAX];

    logic [QUOT_W-1:0]      quot;
    logic [31:0]            quot_x10;
    logic [3:0]             digit;
    logic                   dig_we;
    logic [DIG_IDX_W-1:0]   wr_idx;
    logic [DIG_IDX_W-1:0]   rd_idx;
    logic                   out_free;
    logic                   in_neg;
    logic [DIG_CNT_W-1:0]   dig_cnt_inc;

    // Quotient and remainder of the current magnitude by ten
    assign quot        = prod_reg[63:RECIP_SHIFT];
    assign quot_x10    = (32'(quot) << 3) + (32'(quot) << 1);
    assign digit       = 4'(mag_reg - quot_x10);
    assign dig_cnt_inc = dig_cnt_reg + DIG_CNT_W'(1);
    assign wr_idx      = dig_cnt_reg[DIG_IDX_W-1:0];
    assign rd_idx      = DIG_IDX_W'(dig_cnt_reg - DIG_CNT_W'(1));
    assign out_free    = !m_valid_reg || m_ready;
    assign in_neg      = s_value[31];

    // Sequencer and output register
    always_comb begin
        state_next     = state_reg;
        dig_cnt_next   = dig_cnt_reg;
        sign_pend_next = sign_pend_reg;
        sign_char_next = sign_char_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        m_valid_next   = m_valid_reg;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;
        dig_we         = 1'b0;

        // drop the output beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mag_next     = in_neg ? (~s_value + 32'd1) : s_value;
                    dig_cnt_next = '0;
                    if (in_neg) begin
                        sign_pend_next = 1'b1;
                        sign_char_next = CHAR_MINUS;
                    end else begin
                        case (sign_mode_reg)
                            SIGN_PLUS: begin
                                sign_pend_next = 1'b1;
                                sign_char_next = CHAR_PLUS;
                            end
                            SIGN_SPACE: begin
                                sign_pend_next = 1'b1;
                                sign_char_next = CHAR_SPACE;
                            end
                            default: begin
                                sign_pend_next = 1'b0;
                                sign_char_next = CHAR_SPACE;
                            end
                        endcase
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = 64'(mag_reg) * 64'(RECIP_TEN);
                state_next = ST_DIGIT;
            end
            ST_DIGIT: begin
                // store the low digit, advance to the quotient
                dig_we       = 1'b1;
                mag_next     = 32'(quot);
                dig_cnt_next = dig_cnt_inc;
                if (quot == '0 || dig_cnt_inc == DIG_CNT_W'(DIGITS_MAX)) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sign_pend_reg) begin
                        m_char_next    = sign_char_reg;
                        m_last_next    = 1'b0;
                        sign_pend_next = 1'b0;
                    end else begin
                        m_char_next  = CHAR_ZERO + {4'b0, digits_reg[rd_idx]};
                        m_last_next  = (dig_cnt_reg == DIG_CNT_W'(1));
                        dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                        if (dig_cnt_reg == DIG_CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sign_mode_reg <= SIGN_NONE;
            dig_cnt_reg   <= '0;
            sign_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dig_cnt_reg   <= dig_cnt_next;
            sign_pend_reg <= sign_pend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                sign_mode_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mag_reg       <= mag_next;
        prod_reg      <= prod_next;
        sign_char_reg <= sign_char_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
        if (dig_we) begin
            digits_reg[wr_idx] <= digit;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_last     = m_last_reg;

    // Checks
    `SIDA_ASSERT_NOW(a_cnt_range, aclk, aresetn, 1'b1,
        dig_cnt_reg <= DIG_CNT_W'(DIGITS_MAX), "digit count beyond ten")
    `SIDA_ASSERT_NOW(a_emit_nonempty, aclk, aresetn, state_reg == ST_EMIT,
        dig_cnt_reg != '0, "emit with no digits stored")
    `SIDA_ASSERT_NEXT(a_accept_mul, aclk, aresetn, s_valid && s_ready,
        state_reg == ST_MUL, "accepted beat did not start conversion")
    `SIDA_ASSERT_NOW(a_sign_not_last, aclk, aresetn,
        m_valid && (m_out_char == CHAR_MINUS || m_out_char == CHAR_PLUS
        || m_out_char == CHAR_SPACE), !m_last, "sign character marked last")

endmodule

`default_nettype wire
